/* hw/rtl/segtree_pkg.sv */
// segtree_pkg: widths, constants and codes shared by the range-minimum tree
// used by segtree_if.sv and segment_tree_range_min_top.sv, depends on nothing
package segtree_pkg;

    // payload widths fixed by the item format
    localparam int DATA_W = 48;
    localparam int IDX_W  = 10;
    localparam int SLOT_W = 11;

    // default tree capacity
    localparam int DEF_MAX_SLOTS = 1024;

    // value of a node that holds no slot, and of a query that covers none
    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = 48'sd1000000007;

    // register file
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic SLOTS_RESET_EN = 1'b1;
    localparam logic [SLOT_W-1:0] SLOTS_RESET = 11'd1024;
    localparam logic REG_IDX_SLOTS = 1'b0;

    // item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

endpackage

/* hw/rtl/segtree_if.sv */
// segtree_if: valid/ready channels for tree requests and query results
// depends on segtree_pkg for payload widths

interface segtree_req_if
    import segtree_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [IDX_W-1:0]         write_index;
    logic signed [DATA_W-1:0] write_value;
    logic [IDX_W-1:0]         range_first;
    logic [IDX_W-1:0]         range_last;

    modport source (
        output valid, func, write_index, write_value, range_first, range_last,
        input  ready
    );
    modport sink (
        input  valid, func, write_index, write_value, range_first, range_last,
        output ready
    );
endinterface

interface segtree_rsp_if
    import segtree_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] range_minimum;

    modport source (
        output valid, range_minimum,
        input  ready
    );
    modport sink (
        input  valid, range_minimum,
        output ready
    );
endinterface

/* hw/rtl/segment_tree_range_min_top.sv */
// Range-minimum tree: writes walk down to the leaf and back up to the root,
// queries descend until the range is one node or splits, then follow both
// boundary paths, one tree level per cycle through the node memory; ready
// returns once the request is done, one request at a time; a finished result
// waits in the output register; reset: a clearing pass fills all 4*MAX_SLOTS
// nodes with the empty value, input ready low meanwhile; configuration writes are taken at any time
module segment_tree_range_min_top
    import segtree_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    segtree_req_if.sink           req,
    segtree_rsp_if.source         rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int DEPTH = 4 * MAX_SLOTS;
    localparam int NW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WDESC,
        ST_WUP,
        ST_QDESC,
        ST_QPATHS,
        ST_QDRAIN
    } state_t;

    typedef logic [NW-1:0]     node_t;
    typedef logic [SLOT_W-1:0] span_t;

    function automatic node_t child_l(input node_t k);
        child_l = {k[NW-2:0], 1'b0} + NW'(1);
    endfunction

    function automatic node_t child_r(input node_t k);
        child_r = {k[NW-2:0], 1'b0} + NW'(2);
    endfunction

    function automatic node_t parent_of(input node_t k);
        parent_of = (k - NW'(1)) >> 1;
    endfunction

    function automatic node_t sibling_of(input node_t k);
        sibling_of = k[0] ? (k + NW'(1)) : (k - NW'(1));
    endfunction

    // configuration register
    span_t slots_reg;
    logic  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_SLOTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= SLOTS_RESET;
        end
        else if (cfg_wr)
        begin
            slots_reg <= pwdata[SLOT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_IDX_SLOTS)
        begin
            prdata = {{(APB_DATA_W-SLOT_W){1'b0}}, slots_reg};
        end
    end

    // state and walk registers
    state_t                   state_reg;
    node_t                    clr_cnt_reg;
    logic signed [DATA_W-1:0] val_reg;
    span_t                    idx_reg;
    span_t                    first_reg;
    span_t                    last_reg;
    node_t                    node_reg;
    span_t                    lo_reg;
    span_t                    hi_reg;
    node_t                    rnode_reg;
    span_t                    rlo_reg;
    span_t                    rhi_reg;
    logic                     lact_reg;
    logic                     ract_reg;
    logic                     rva_reg;
    logic                     rvb_reg;
    logic signed [DATA_W-1:0] pair_reg;
    logic                     pair_vld_reg;
    logic signed [DATA_W-1:0] acc_reg;
    logic                     acc_vld_reg;
    logic                     rsp_val_reg;
    logic signed [DATA_W-1:0] rsp_data_reg;

    // node memory, one write and two read ports
    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_a_q;
    logic signed [DATA_W-1:0] rd_b_q;
    logic                     mem_we;
    node_t                    mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic                     rd_en_a;
    node_t                    rd_addr_a;
    logic                     rd_en_b;
    node_t                    rd_addr_b;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en_a)
        begin
            rd_a_q <= mem[rd_addr_a];
        end
        if (rd_en_b)
        begin
            rd_b_q <= mem[rd_addr_b];
        end
    end

    // active slot count and request decode
    span_t n_act;
    span_t top_hi;
    span_t last_clip;
    logic  accept;
    logic  write_ok;
    logic  query_ok;

    assign n_act     = (32'(slots_reg) > MAX_SLOTS) ? SLOT_W'(MAX_SLOTS) : slots_reg;
    assign top_hi    = n_act - SLOT_W'(1);
    assign last_clip = ({1'b0, req.range_last} <= top_hi) ? {1'b0, req.range_last} : top_hi;
    assign write_ok  = (n_act != '0) && ({1'b0, req.write_index} < n_act);
    assign query_ok  = (n_act != '0) && ({1'b0, req.range_first} <= last_clip);

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign rsp.valid         = rsp_val_reg;
    assign rsp.range_minimum = rsp_data_reg;

    // split points of the current nodes
    span_t mid_l;
    span_t mid_r;
    node_t up_node;
    logic signed [DATA_W-1:0] up_min;
    logic  l_take;
    logic  r_take;
    logic  post_rsp;

    assign mid_l   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign mid_r   = rlo_reg + ((rhi_reg - rlo_reg) >> 1);
    assign up_node = parent_of(node_reg);
    assign up_min  = (rd_a_q < val_reg) ? rd_a_q : val_reg;
    assign l_take  = (first_reg == lo_reg);
    assign r_take  = (last_reg == rhi_reg);

    // result ready to post once reads have folded in and the output is free
    assign post_rsp = (state_reg == ST_QDRAIN) && !rva_reg && !rvb_reg && !pair_vld_reg &&
                      (!rsp_val_reg || rsp.ready);

    // memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = EMPTY_VALUE;
        rd_en_a   = 1'b0;
        rd_addr_a = '0;
        rd_en_b   = 1'b0;
        rd_addr_b = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
            end
            ST_WDESC:
            begin
                if (lo_reg == hi_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = node_reg;
                    mem_wdata = val_reg;
                    if (node_reg != '0)
                    begin
                        rd_en_a   = 1'b1;
                        rd_addr_a = sibling_of(node_reg);
                    end
                end
            end
            ST_WUP:
            begin
                mem_we    = 1'b1;
                mem_waddr = up_node;
                mem_wdata = up_min;
                if (up_node != '0)
                begin
                    rd_en_a   = 1'b1;
                    rd_addr_a = sibling_of(up_node);
                end
            end
            ST_QDESC:
            begin
                if (l_take && (last_reg == hi_reg))
                begin
                    rd_en_a   = 1'b1;
                    rd_addr_a = node_reg;
                end
            end
            ST_QPATHS:
            begin
                if (lact_reg)
                begin
                    if (l_take)
                    begin
                        rd_en_a   = 1'b1;
                        rd_addr_a = node_reg;
                    end
                    else if (first_reg <= mid_l)
                    begin
                        rd_en_a   = 1'b1;
                        rd_addr_a = child_r(node_reg);
                    end
                end
                if (ract_reg)
                begin
                    if (r_take)
                    begin
                        rd_en_b   = 1'b1;
                        rd_addr_b = rnode_reg;
                    end
                    else if (last_reg > mid_r)
                    begin
                        rd_en_b   = 1'b1;
                        rd_addr_b = child_l(rnode_reg);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // sequencer, minimum pipeline and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            val_reg      <= '0;
            idx_reg      <= '0;
            first_reg    <= '0;
            last_reg     <= '0;
            node_reg     <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            rnode_reg    <= '0;
            rlo_reg      <= '0;
            rhi_reg      <= '0;
            lact_reg     <= 1'b0;
            ract_reg     <= 1'b0;
            rva_reg      <= 1'b0;
            rvb_reg      <= 1'b0;
            pair_reg     <= '0;
            pair_vld_reg <= 1'b0;
            acc_reg      <= '0;
            acc_vld_reg  <= 1'b0;
            rsp_val_reg  <= 1'b0;
            rsp_data_reg <= '0;
        end
        else
        begin
            // read data valid tracking and running minimum
            rva_reg      <= rd_en_a && (state_reg == ST_QDESC || state_reg == ST_QPATHS);
            rvb_reg      <= rd_en_b;
            pair_vld_reg <= rva_reg || rvb_reg;
            if (rva_reg && rvb_reg)
            begin
                pair_reg <= (rd_b_q < rd_a_q) ? rd_b_q : rd_a_q;
            end
            else if (rva_reg)
            begin
                pair_reg <= rd_a_q;
            end
            else
            begin
                pair_reg <= rd_b_q;
            end
            if (pair_vld_reg && (!acc_vld_reg || (pair_reg < acc_reg)))
            begin
                acc_reg     <= pair_reg;
                acc_vld_reg <= 1'b1;
            end

            // post a new result, or clear the one taken downstream
            if (post_rsp)
            begin
                rsp_val_reg  <= 1'b1;
                rsp_data_reg <= acc_reg;
            end
            else if (rsp_val_reg && rsp.ready)
            begin
                rsp_val_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + NW'(1);
                    if (clr_cnt_reg == NW'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        val_reg   <= req.write_value;
                        idx_reg   <= {1'b0, req.write_index};
                        first_reg <= {1'b0, req.range_first};
                        last_reg  <= last_clip;
                        node_reg  <= '0;
                        lo_reg    <= '0;
                        hi_reg    <= top_hi;
                        lact_reg  <= 1'b0;
                        ract_reg  <= 1'b0;
                        if (req.func == FUNC_WRITE)
                        begin
                            if (write_ok)
                            begin
                                state_reg <= ST_WDESC;
                            end
                        end
                        else if (query_ok)
                        begin
                            // the empty value joins the minimum unless the
                            // range covers the whole tree
                            acc_reg     <= EMPTY_VALUE;
                            acc_vld_reg <= !((req.range_first == '0) && (last_clip == top_hi));
                            state_reg   <= ST_QDESC;
                        end
                        else
                        begin
                            acc_reg     <= EMPTY_VALUE;
                            acc_vld_reg <= 1'b1;
                            state_reg   <= ST_QDRAIN;
                        end
                    end
                end
                ST_WDESC:
                begin
                    // walk down to the leaf of the slot
                    if (lo_reg == hi_reg)
                    begin
                        state_reg <= (node_reg == '0) ? ST_IDLE : ST_WUP;
                    end
                    else if (idx_reg <= mid_l)
                    begin
                        node_reg <= child_l(node_reg);
                        hi_reg   <= mid_l;
                    end
                    else
                    begin
                        node_reg <= child_r(node_reg);
                        lo_reg   <= mid_l + SLOT_W'(1);
                    end
                end
                ST_WUP:
                begin
                    // refresh one ancestor per cycle up to the root
                    val_reg  <= up_min;
                    node_reg <= up_node;
                    if (up_node == '0)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_QDESC:
                begin
                    // descend until the range is one node or splits
                    if (l_take && (last_reg == hi_reg))
                    begin
                        state_reg <= ST_QDRAIN;
                    end
                    else if (last_reg <= mid_l)
                    begin
                        node_reg <= child_l(node_reg);
                        hi_reg   <= mid_l;
                    end
                    else if (first_reg > mid_l)
                    begin
                        node_reg <= child_r(node_reg);
                        lo_reg   <= mid_l + SLOT_W'(1);
                    end
                    else
                    begin
                        node_reg  <= child_l(node_reg);
                        hi_reg    <= mid_l;
                        rnode_reg <= child_r(node_reg);
                        rlo_reg   <= mid_l + SLOT_W'(1);
                        rhi_reg   <= hi_reg;
                        lact_reg  <= 1'b1;
                        ract_reg  <= 1'b1;
                        state_reg <= ST_QPATHS;
                    end
                end
                ST_QPATHS:
                begin
                    // left boundary path
                    if (lact_reg)
                    begin
                        if (l_take)
                        begin
                            lact_reg <= 1'b0;
                        end
                        else if (first_reg <= mid_l)
                        begin
                            node_reg <= child_l(node_reg);
                            hi_reg   <= mid_l;
                        end
                        else
                        begin
                            node_reg <= child_r(node_reg);
                            lo_reg   <= mid_l + SLOT_W'(1);
                        end
                    end
                    // right boundary path
                    if (ract_reg)
                    begin
                        if (r_take)
                        begin
                            ract_reg <= 1'b0;
                        end
                        else if (last_reg > mid_r)
                        begin
                            rnode_reg <= child_r(rnode_reg);
                            rlo_reg   <= mid_r + SLOT_W'(1);
                        end
                        else
                        begin
                            rnode_reg <= child_l(rnode_reg);
                            rhi_reg   <= mid_r;
                        end
                    end
                    if ((!lact_reg || l_take) && (!ract_reg || r_take))
                    begin
                        state_reg <= ST_QDRAIN;
                    end
                end
                ST_QDRAIN:
                begin
                    // wait for the last reads to fold in, then post the result
                    if (post_rsp)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
